### sv/sc3_pkg.sv
`timescale 1ns / 1ps

package sc3_pkg;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_HMAC = 5'b00010,
		S_HRND = 5'b00100,
		S_VMAC = 5'b01000,
		S_VOUT = 5'b10000
	} sc3_state_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_ROW_LEFT   = 3'd0;
	localparam logic [2:0] REG_ROW_CENTER = 3'd1;
	localparam logic [2:0] REG_ROW_RIGHT  = 3'd2;
	localparam logic [2:0] REG_COL_TOP    = 3'd3;
	localparam logic [2:0] REG_COL_MIDDLE = 3'd4;
	localparam logic [2:0] REG_COL_BOTTOM = 3'd5;
	localparam logic [2:0] REG_WIDTH      = 3'd6;
	localparam logic [2:0] REG_HEIGHT     = 3'd7;

	localparam int TAP_W = 16;

endpackage

### sv/sc3_ram.sv
`timescale 1ns / 1ps

module sc3_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/separable_conv3x3_replicate.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// cfg       cfg_valid/cfg_ready   cfg_index[2:0], cfg_data[15:0]
// in        in_valid/in_stall     pixel_value
// out       out_valid/out_stall   result_value, out_row, out_column, last_in_run, frame_end
//
// An item is taken while the sequencer is idle; in_stall holds off new items
// until it is idle again. Each horizontal tap sum then takes 3 multiply-accumulate
// steps and a rounding step, and each result a further multiply-accumulate pass
// and an output step that waits out any output stall, all through one shared
// multiplier. An item causes 0 to 2 horizontal sums and up to 4 results.
// Reset (arst_n low) returns the taps, size and counters to their defaults;
// the line store has no reset and needs none.

module separable_conv3x3_replicate
	import sc3_pkg::*;
#(
	parameter int MAX_WIDTH     = 4096,
	parameter int PIXEL_BITS    = 16,
	parameter int TAP_FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [15:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [PIXEL_BITS-1:0] pixel_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [PIXEL_BITS-1:0] result_value,
	output logic [15:0]                  out_row,
	output logic [11:0]                  out_column,
	output logic                         last_in_run,
	output logic                         frame_end
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = PIXEL_BITS + 2;
	localparam int PROD_W = TAP_W + ROW_W;
	localparam int ACC_W  = PROD_W + 2;

	// Configuration registers. Writes are always taken.
	logic signed [TAP_W-1:0] taps_q [6];
	logic [12:0]             width_q;
	logic [15:0]             height_q;

	logic [COL_W-1:0] col_cnt_q;
	logic [15:0]      row_cnt_q;
	logic signed [PIXEL_BITS-1:0] hist0_q, hist1_q;

	sc3_state_t state_q;
	logic [1:0] k_q;
	logic       second_q, vsel_q, lastrow_q;
	logic [COL_W-1:0] col_q;
	logic [15:0]      cur_row_q;
	logic signed [ROW_W-1:0] xl_q, xc_q, xr_q;
	logic signed [ROW_W-1:0] vl_q, vc_q, vr_q;
	logic signed [ACC_W-1:0] acc_q;

	logic out_valid_q;
	logic signed [PIXEL_BITS-1:0] res_q;
	logic [15:0] row_o_q;
	logic [11:0] col_o_q;
	logic        last_o_q, fend_o_q;

	assign cfg_ready = 1'b1;

	// Effective frame size: zero reads as one, wide rows are clipped.
	logic [COL_W:0]   w_eff;
	logic [COL_W-1:0] w_m1;
	logic [15:0]      h_m1;
	logic [COL_W-1:0] c_eff;
	logic             is_last_col;

	always_comb begin
		if (width_q == 13'd0) begin
			w_eff = (COL_W+1)'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			w_eff = (COL_W+1)'(width_q);
		end
		w_m1        = COL_W'(w_eff - (COL_W+1)'(1));
		h_m1        = (height_q == 16'd0) ? 16'd0 : height_q - 16'd1;
		c_eff       = (col_cnt_q >= w_m1) ? w_m1 : col_cnt_q;
		is_last_col = (c_eff == w_m1);
	end

	logic accept;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	logic signed [ROW_W-1:0] p_ext, h0_ext, h1_ext;
	assign p_ext  = ROW_W'(pixel_value);
	assign h0_ext = ROW_W'(hist0_q);
	assign h1_ext = ROW_W'(hist1_q);

	// Shared multiply-accumulate: the step counter picks tap and operand.
	logic signed [TAP_W-1:0] mac_tap;
	logic signed [ROW_W-1:0] mac_opnd;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		if (state_q == S_VMAC) begin
			mac_tap  = taps_q[3'd3 + {1'b0, k_q}];
			mac_opnd = (k_q == 2'd0) ? vl_q : ((k_q == 2'd1) ? vc_q : vr_q);
		end else begin
			mac_tap  = taps_q[{1'b0, k_q}];
			mac_opnd = (k_q == 2'd0) ? xl_q : ((k_q == 2'd1) ? xc_q : xr_q);
		end
		prod = mac_tap * mac_opnd;
	end

	// Rounding to nearest (half up) and saturation of the accumulator.
	logic signed [ACC_W:0] rnd_sum, rnd_sh;
	logic signed [ROW_W-1:0]      f_row;
	logic signed [PIXEL_BITS-1:0] f_pix;

	always_comb begin
		rnd_sum = (ACC_W+1)'(acc_q) + ((ACC_W+1)'(1) <<< (TAP_FRAC_BITS - 1));
		rnd_sh  = rnd_sum >>> TAP_FRAC_BITS;
		if (rnd_sh > (ACC_W+1)'((64'sd1 <<< (ROW_W - 1)) - 1)) begin
			f_row = {1'b0, {(ROW_W-1){1'b1}}};
		end else if (rnd_sh < -(ACC_W+1)'(64'sd1 <<< (ROW_W - 1))) begin
			f_row = {1'b1, {(ROW_W-1){1'b0}}};
		end else begin
			f_row = ROW_W'(rnd_sh);
		end
		if (rnd_sh > (ACC_W+1)'((64'sd1 <<< (PIXEL_BITS - 1)) - 1)) begin
			f_pix = {1'b0, {(PIXEL_BITS-1){1'b1}}};
		end else if (rnd_sh < -(ACC_W+1)'(64'sd1 <<< (PIXEL_BITS - 1))) begin
			f_pix = {1'b1, {(PIXEL_BITS-1){1'b0}}};
		end else begin
			f_pix = PIXEL_BITS'(rnd_sh);
		end
	end

	// Line store: older row in the upper half, newer row in the lower half.
	logic [2*ROW_W-1:0] rd_data;
	logic [2*ROW_W-1:0] wr_data;
	logic               mem_we, mem_re;
	logic signed [ROW_W-1:0] line_a, line_b;

	assign line_a  = rd_data[2*ROW_W-1:ROW_W];
	assign line_b  = rd_data[ROW_W-1:0];
	assign mem_re  = (state_q == S_HMAC) && (k_q == 2'd0);
	assign mem_we  = (state_q == S_HRND);
	assign wr_data = (cur_row_q == 16'd0) ? {f_row, f_row} : {line_b, f_row};

	sc3_ram #(
		.WIDTH(2 * ROW_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.we     (mem_we),
		.wr_addr(col_q),
		.wr_data(wr_data),
		.rd_en  (mem_re),
		.rd_addr(col_q),
		.rd_data(rd_data)
	);

	// Whether a horizontal sum in the current row leads to any result.
	logic has_res;
	logic out_free;
	logic res_last;
	assign has_res  = (cur_row_q != 16'd0) || lastrow_q;
	assign out_free = !out_valid_q || !out_stall;
	assign res_last = !(!vsel_q && lastrow_q) && !(second_q && has_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q[0]   <= '0;
			taps_q[1]   <= 16'sd16384;
			taps_q[2]   <= '0;
			taps_q[3]   <= '0;
			taps_q[4]   <= 16'sd16384;
			taps_q[5]   <= '0;
			width_q     <= 13'd640;
			height_q    <= 16'd480;
			col_cnt_q   <= '0;
			row_cnt_q   <= '0;
			hist0_q     <= '0;
			hist1_q     <= '0;
			state_q     <= S_IDLE;
			k_q         <= '0;
			second_q    <= 1'b0;
			vsel_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				hist1_q <= hist0_q;
				hist0_q <= pixel_value;
				if (is_last_col) begin
					col_cnt_q <= '0;
					row_cnt_q <= (row_cnt_q >= h_m1) ? 16'd0 : row_cnt_q + 16'd1;
				end else begin
					col_cnt_q <= c_eff + COL_W'(1);
				end
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ROW_LEFT:   taps_q[0] <= cfg_data;
					REG_ROW_CENTER: taps_q[1] <= cfg_data;
					REG_ROW_RIGHT:  taps_q[2] <= cfg_data;
					REG_COL_TOP:    taps_q[3] <= cfg_data;
					REG_COL_MIDDLE: taps_q[4] <= cfg_data;
					REG_COL_BOTTOM: taps_q[5] <= cfg_data;
					REG_WIDTH: begin
						width_q   <= cfg_data[12:0];
						col_cnt_q <= '0;
						row_cnt_q <= '0;
					end
					REG_HEIGHT: begin
						height_q  <= cfg_data;
						col_cnt_q <= '0;
						row_cnt_q <= '0;
					end
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (accept && ((w_eff == (COL_W+1)'(1)) || (c_eff != '0))) begin
						state_q <= S_HMAC;
					end
					if (w_eff == (COL_W+1)'(1)) begin
						second_q <= 1'b0;
					end else begin
						second_q <= is_last_col;
					end
				end
				S_HMAC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_HRND;
					end
				end
				S_HRND: begin
					if (cur_row_q != 16'd0) begin
						vsel_q  <= 1'b0;
						state_q <= S_VMAC;
					end else if (lastrow_q) begin
						vsel_q  <= 1'b1;
						state_q <= S_VMAC;
					end else if (second_q) begin
						second_q <= 1'b0;
						state_q  <= S_HMAC;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_VMAC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_VOUT;
					end
				end
				S_VOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!vsel_q && lastrow_q) begin
							vsel_q  <= 1'b1;
							state_q <= S_VMAC;
						end else if (second_q) begin
							second_q <= 1'b0;
							state_q  <= S_HMAC;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_row_q <= row_cnt_q;
			lastrow_q <= (row_cnt_q == h_m1);
			if (w_eff == (COL_W+1)'(1)) begin
				col_q <= '0;
				xl_q  <= p_ext;
				xc_q  <= p_ext;
				xr_q  <= p_ext;
			end else begin
				col_q <= c_eff - COL_W'(1);
				xl_q  <= (c_eff == COL_W'(1)) ? h0_ext : h1_ext;
				xc_q  <= h0_ext;
				xr_q  <= p_ext;
			end
		end

		if ((state_q == S_HMAC) || (state_q == S_VMAC)) begin
			acc_q <= ((k_q == 2'd0) ? '0 : acc_q) + ACC_W'(prod);
		end

		if (state_q == S_HRND) begin
			if (cur_row_q != 16'd0) begin
				vl_q <= line_a;
				vc_q <= line_b;
				vr_q <= f_row;
			end else begin
				vl_q <= f_row;
				vc_q <= f_row;
				vr_q <= f_row;
			end
		end

		// Advance to the rightmost column of the row (the second sum).
		if (((state_q == S_HRND) && !has_res && second_q) ||
		    ((state_q == S_VOUT) && out_free && !(!vsel_q && lastrow_q) && second_q)) begin
			col_q <= col_q + COL_W'(1);
			xl_q  <= xc_q;
			xc_q  <= xr_q;
		end

		// After the upper result the last-row result uses the updated line.
		if ((state_q == S_VOUT) && out_free && !vsel_q && lastrow_q) begin
			vl_q <= vc_q;
			vc_q <= vr_q;
		end

		if ((state_q == S_VOUT) && out_free) begin
			res_q    <= f_pix;
			row_o_q  <= vsel_q ? cur_row_q : cur_row_q - 16'd1;
			col_o_q  <= 12'(col_q);
			last_o_q <= res_last;
			fend_o_q <= vsel_q && (col_q == w_m1);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_q;
	assign out_row      = row_o_q;
	assign out_column   = col_o_q;
	assign last_in_run  = last_o_q;
	assign frame_end    = fend_o_q;

endmodule
